[src/lrf_pkg.sv]
`timescale 1ns / 1ps
// shared types, sizes and codes of the load record framer
// no dependencies
`default_nettype none

package lrf_pkg;

  // buffered block size in bytes, 1 to 256
  localparam int BLOCK_BYTES = 256;
  localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);
  localparam int WORDS       = (BLOCK_BYTES + 7) / 8;
  localparam int WA_W        = (WORDS > 1) ? $clog2(WORDS) : 1;

  localparam logic [1:0] ACT_DATA = 2'd0;
  localparam logic [1:0] ACT_XFER = 2'd1;
  localparam logic [1:0] ACT_END  = 2'd2;

  localparam logic [7:0] REC_LOAD = 8'h01;
  localparam logic [7:0] REC_XFER = 8'h02;
  localparam logic [7:0] REC_END  = 8'h03;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  value;
  } in_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last_of_run;
  } out_t;

  // one data chunk cut from a buffer word
  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        is_last;
  } chunk_t;

endpackage

`default_nettype wire

[src/lrf_ram.sv]
`timescale 1ns / 1ps
// generic simple dual-port ram, registered read with read enable
// no dependencies
`default_nettype none

module lrf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/lrf_chunk.sv]
`timescale 1ns / 1ps
// cuts one data chunk of up to eight bytes from a buffer word
// depends on lrf_pkg
`default_nettype none

module lrf_chunk (
  input  wire logic [63:0]  word,
  input  wire logic [15:0]  remain,
  output lrf_pkg::chunk_t   chunk
);
  import lrf_pkg::*;

  logic [3:0] n;

  always_comb begin
    n             = (remain > 16'd8) ? 4'd8 : remain[3:0];
    chunk.count   = n;
    chunk.is_last = (remain <= 16'd8);
    for (int i = 0; i < 8; i++) begin
      // bytes past the chunk end read as zero
      chunk.bytes[8*i +: 8] = (4'(i) < n) ? word[8*i +: 8] : 8'h00;
    end
  end

endmodule

`default_nettype wire

[src/load_record_framer.sv]
`timescale 1ns / 1ps
// load record framer top level: sequencer, block buffer ram, output register
// depends on lrf_pkg, lrf_ram, lrf_chunk
//
//  channel   ports                           beat
//  input     in_valid  in_stall  in_data     action, address, value
//  output    out_valid out_stall out_data    out_bytes, byte_count, last_of_run
//
// a data byte that joins the run is accepted with a buffer word read, then merged
// and written back into the word ram in S_WR
// a flush emits a load record header beat, then one beat per chunk of up to 8 bytes,
// with the chunk reads paced by the single ram read port
// transfer and end records emit one beat each after any flush
// rst_n is synchronous; the buffer ram is not cleared, only bytes below the
// fill count are ever output; output stalls hold the sequencer in its record states
`default_nettype none

module load_record_framer (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire lrf_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output lrf_pkg::out_t     out_data
);
  import lrf_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDR  = 3'd1;  // emit load record header
  localparam logic [2:0] S_FOUT = 3'd2;  // emit data chunks
  localparam logic [2:0] S_TREC = 3'd3;  // emit transfer record
  localparam logic [2:0] S_EREC = 3'd4;  // emit end record
  localparam logic [2:0] S_WR   = 3'd5;  // merge byte, write word back

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      start_r, start_nxt;
  logic [15:0]      prev_r, prev_nxt;
  logic             prev_valid_r, prev_valid_nxt;
  logic             xfer_seen_r, xfer_seen_nxt;
  logic [WA_W-1:0]  w_r, w_nxt;
  in_t              item_r, item_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  // buffer ram port signals
  logic             rd_en, wr_en;
  logic [WA_W-1:0]  rd_addr, wr_addr;
  logic [63:0]      rd_data, wr_data;

  logic             accept;
  logic             out_free;
  logic             run, brk;
  logic [15:0]      count16;
  logic [WA_W-1:0]  cnt_word;
  logic [2:0]       cnt_lane;
  logic [15:0]      remain;
  logic [15:0]      hdr_len;
  chunk_t           chunk;

  lrf_ram #(
    .WIDTH (64),
    .DEPTH (WORDS)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lrf_chunk u_chunk (
    .word   (rd_data),
    .remain (remain),
    .chunk  (chunk)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  // output register can take a new beat this cycle
  assign out_free  = !out_valid_r || !out_stall;

  assign count16  = 16'(count_r);
  assign cnt_word = WA_W'(count16 >> 3);
  assign cnt_lane = count16[2:0];
  assign remain   = count16 - 16'({w_r, 3'b000});
  assign hdr_len  = count16 + 16'd2;

  // run test on the incoming item; the address space does not wrap
  assign run = prev_valid_r && (prev_r != 16'hFFFF) &&
               (in_data.address == prev_r + 16'd1);
  assign brk = !run || (count16 >= 16'(BLOCK_BYTES));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    start_nxt      = start_r;
    prev_nxt       = prev_r;
    prev_valid_nxt = prev_valid_r;
    xfer_seen_nxt  = xfer_seen_r;
    w_nxt          = w_r;
    item_nxt       = item_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    rd_en          = 1'b0;
    rd_addr        = cnt_word;
    wr_en          = 1'b0;
    wr_addr        = cnt_word;
    wr_data        = rd_data;
    wr_data[8*cnt_lane +: 8] = item_r.value;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_data;
          unique case (in_data.action)
            ACT_DATA: begin
              if (brk && (count_r != '0)) begin
                state_nxt = S_HDR;
              end else begin
                if (brk) begin
                  start_nxt = in_data.address;
                end
                rd_en     = 1'b1;
                state_nxt = S_WR;
              end
            end
            ACT_XFER: begin
              state_nxt = (count_r != '0) ? S_HDR : S_TREC;
            end
            ACT_END: begin
              // end after a transfer does nothing at all
              if (!xfer_seen_r) begin
                state_nxt = (count_r != '0) ? S_HDR : S_EREC;
              end
            end
            default: begin
              // unused action code is dropped
            end
          endcase
        end
      end
      S_HDR: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.out_bytes     = {32'd0, start_r[15:8], start_r[7:0],
                                   hdr_len[7:0], REC_LOAD};
          out_nxt.byte_count    = 4'd4;
          out_nxt.last_of_run   = 1'b0;
          rd_en                 = 1'b1;
          rd_addr               = '0;
          w_nxt                 = '0;
          state_nxt             = S_FOUT;
        end
      end
      S_FOUT: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.out_bytes   = chunk.bytes;
          out_nxt.byte_count  = chunk.count;
          // a data item ends its run on the flush itself
          out_nxt.last_of_run = chunk.is_last && (item_r.action == ACT_DATA);
          if (!chunk.is_last) begin
            // keep the read one word ahead
            rd_en   = 1'b1;
            rd_addr = w_r + WA_W'(1);
            w_nxt   = w_r + WA_W'(1);
          end else begin
            count_nxt = '0;
            if (item_r.action == ACT_DATA) begin
              start_nxt = item_r.address;
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_WR;
            end else if (item_r.action == ACT_XFER) begin
              state_nxt = S_TREC;
            end else begin
              state_nxt = S_EREC;
            end
          end
        end
      end
      S_TREC: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.out_bytes   = {32'd0, item_r.address[15:8], item_r.address[7:0],
                                 REC_XFER, REC_XFER};
          out_nxt.byte_count  = 4'd4;
          out_nxt.last_of_run = 1'b1;
          prev_nxt            = item_r.address;
          start_nxt           = item_r.address;
          prev_valid_nxt      = 1'b1;
          xfer_seen_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      S_EREC: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.out_bytes   = {56'd0, REC_END};
          out_nxt.byte_count  = 4'd1;
          out_nxt.last_of_run = 1'b1;
          prev_nxt            = 16'd0;
          start_nxt           = 16'd0;
          prev_valid_nxt      = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      S_WR: begin
        // read-modify-write of the word that holds the new byte
        wr_en          = 1'b1;
        count_nxt      = count_r + CNT_W'(1);
        prev_nxt       = item_r.address;
        prev_valid_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      start_r      <= '0;
      prev_r       <= '0;
      prev_valid_r <= 1'b0;
      xfer_seen_r  <= 1'b0;
      w_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      start_r      <= start_nxt;
      prev_r       <= prev_nxt;
      prev_valid_r <= prev_valid_nxt;
      xfer_seen_r  <= xfer_seen_nxt;
      w_r          <= w_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  // fill count never passes the block size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count16 <= 16'(BLOCK_BYTES))
    else $error("block fill count above block size");

  // a write-back only lands inside the block
  a_wr_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (count16 < 16'(BLOCK_BYTES)))
    else $error("buffer write past block end");

  // the sequencer never reads and writes the buffer ram in one cycle
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("buffer read and write in same cycle");

  // a stalled output holds the chunk sequencer in S_FOUT
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && (state_r == S_FOUT)) |=> (state_r == S_FOUT))
    else $error("chunk sequencer moved under output stall");

  // every beat carries one to eight bytes
  a_beat_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.byte_count != 4'd0) && (out_r.byte_count <= 4'd8)))
    else $error("output beat byte count out of range");

endmodule

`default_nettype wire

[tb/tb_load_record_framer.sv]
`timescale 1ns / 1ps
// self-checking bench for load_record_framer: directed rows and random runs of
// address/byte beats in turn, with an in-bench record predictor and in-order result check
// depends on lrf_pkg and load_record_framer

module tb_load_record_framer;
  import lrf_pkg::*;

  // action code 3 has no meaning, the block must drop it
  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  // second byte of a transfer record, its fixed length field
  localparam logic [7:0] XFER_LEN    = 8'd2;

  localparam int HOLD_AFTER   = 30;    // result beats seen before the long hold-off
  localparam int HOLD_CYCLES  = 300;   // receiver hold-off length
  localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 40;    // settle time after the last expected beat

  // check tag that travels with each input beat: typed rows carry their result
  typedef struct packed {
    logic typed;
    logic has_frame;
    out_t want;
  } check_tag_t;

  typedef struct packed {
    in_t        beat;
    check_tag_t tag;
  } drow_t;

  localparam check_tag_t PREDICT   = '0;
  localparam check_tag_t T_NONE    = {1'b1, 1'b0, 64'd0, 4'd0, 1'b0};
  localparam check_tag_t T_END     = {1'b1, 1'b1, 56'd0, REC_END, 4'd1, 1'b1};
  localparam check_tag_t T_XFER_HI = {1'b1, 1'b1, 32'd0, 16'hFFFF, XFER_LEN, REC_XFER,
                                      4'd4, 1'b1};
  localparam check_tag_t T_XFER_LO = {1'b1, 1'b1, 32'd0, 16'h0000, XFER_LEN, REC_XFER,
                                      4'd4, 1'b1};

  localparam int N_ROWS   = 26;
  localparam int XFER_ROW = 20;  // rows from here on come after the first random phase

  drow_t dir_rows [0:N_ROWS-1] = '{
    {ACT_END,    16'h0000, 8'h00, T_END},     // end right after reset, nothing buffered
    {ACT_DATA,   16'h0001, 8'hFF, PREDICT},   // joins the block that the end started at 0
    {ACT_DATA,   16'h0002, 8'h00, PREDICT},
    {ACT_UNUSED, 16'hFFFF, 8'hFF, T_NONE},    // unused action, dropped
    {ACT_DATA,   16'h0003, 8'hA5, PREDICT},
    {ACT_DATA,   16'h0000, 8'h3C, PREDICT},   // address break flushes
    {ACT_DATA,   16'hFFFF, 8'h5A, PREDICT},   // top address
    {ACT_DATA,   16'h0000, 8'hC3, PREDICT},   // no wrap from the top address
    {ACT_END,    16'h0000, 8'h00, PREDICT},   // end flushes, then end record
    {ACT_END,    16'hFFFF, 8'hFF, T_END},     // end with an empty buffer
    {ACT_DATA,   16'h8000, 8'h80, PREDICT},   // nine bytes: two data chunks
    {ACT_DATA,   16'h8001, 8'h81, PREDICT},
    {ACT_DATA,   16'h8002, 8'h82, PREDICT},
    {ACT_DATA,   16'h8003, 8'h83, PREDICT},
    {ACT_DATA,   16'h8004, 8'h84, PREDICT},
    {ACT_DATA,   16'h8005, 8'h85, PREDICT},
    {ACT_DATA,   16'h8006, 8'h86, PREDICT},
    {ACT_DATA,   16'h8007, 8'h87, PREDICT},
    {ACT_DATA,   16'h8008, 8'h88, PREDICT},
    {ACT_DATA,   16'h8007, 8'h7F, PREDICT},   // backward break
    {ACT_END,    16'h0000, 8'h00, PREDICT},   // clears the buffer before transfers
    {ACT_XFER,   16'hFFFF, 8'h00, T_XFER_HI}, // transfer at the top address
    {ACT_XFER,   16'h0000, 8'hFF, T_XFER_LO}, // transfer at zero
    {ACT_DATA,   16'h0001, 8'h11, PREDICT},   // block start stays at the transfer address
    {ACT_END,    16'h0000, 8'h00, T_NONE},    // end after a transfer does nothing
    {ACT_DATA,   16'h0002, 8'h22, PREDICT}    // run survives the ignored end
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_t        in_data;
  check_tag_t beat_tag;
  logic       out_valid;
  logic       out_stall;
  out_t       out_data;

  load_record_framer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // record predictor state
  logic [7:0]  buf_mem [0:BLOCK_BYTES-1];
  int          buf_fill;
  logic [15:0] buf_base;
  logic [15:0] last_addr;
  logic        last_ok;
  logic        xfer_seen;
  out_t        step_frames[$];
  out_t        pending_frames[$];

  int  beats_in;
  int  frames_seen;
  int  load_records;
  int  mismatches;
  int  quiet_cycles;
  bit  hold_done;
  int  sender_left;
  bit  sender_calm;
  logic [15:0] run_next;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_frame(input logic [63:0] word, input logic [3:0] n);
    out_t f;
    f.out_bytes   = word;
    f.byte_count  = n;
    f.last_of_run = 1'b0;
    step_frames.push_back(f);
  endfunction

  // load record: header, then the buffered bytes in chunks of up to eight
  function automatic void flush_frames();
    logic [63:0] word;
    logic [8:0]  len_field;
    int          pos;
    int          n;
    int          i;
    if (buf_fill == 0) return;
    len_field = 9'(buf_fill + 2);
    push_frame({32'd0, buf_base, len_field[7:0], REC_LOAD}, 4'd4);
    pos = 0;
    while (pos < buf_fill) begin
      n = (buf_fill - pos > 8) ? 8 : buf_fill - pos;
      word = '0;
      for (i = 0; i < n; i++) word[8*i +: 8] = buf_mem[pos + i];
      push_frame(word, n[3:0]);
      pos += n;
    end
    buf_fill = 0;
    load_records++;
  endfunction

  function automatic void predict_records(input in_t b);
    logic joins;
    out_t f;
    step_frames.delete();
    case (b.action)
      ACT_DATA: begin
        joins = last_ok && last_addr != 16'hFFFF && b.address == last_addr + 16'd1;
        if (!joins || buf_fill >= BLOCK_BYTES) begin
          flush_frames();
          buf_base = b.address;
        end
        buf_mem[buf_fill] = b.value;
        buf_fill++;
        last_addr = b.address;
        last_ok   = 1'b1;
      end
      ACT_XFER: begin
        flush_frames();
        last_addr = b.address;
        buf_base  = b.address;
        last_ok   = 1'b1;
        push_frame({32'd0, b.address, XFER_LEN, REC_XFER}, 4'd4);
        xfer_seen = 1'b1;
      end
      ACT_END: begin
        if (!xfer_seen) begin
          flush_frames();
          last_addr = '0;
          buf_base  = '0;
          last_ok   = 1'b1;
          push_frame({56'd0, REC_END}, 4'd1);
        end
      end
      default: ;
    endcase
    if (step_frames.size() > 0) begin
      f = step_frames.pop_back();
      f.last_of_run = 1'b1;
      step_frames.push_back(f);
    end
  endfunction

  // predict on each accepted input beat, check each accepted result beat
  always @(posedge clk) begin : scoreboard
    out_t want;
    if (rst_n && in_valid && !in_stall) begin
      beats_in++;
      predict_records(in_data);
      if (beat_tag.typed) begin
        if (beat_tag.has_frame) pending_frames.push_back(beat_tag.want);
      end else begin
        while (step_frames.size() > 0) pending_frames.push_back(step_frames.pop_front());
      end
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      frames_seen++;
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t unexpected result beat: bytes %h count %0d last %0b",
                   $realtime, out_data.out_bytes, out_data.byte_count,
                   out_data.last_of_run);
      end else begin
        want = pending_frames.pop_front();
        if (out_data.out_bytes !== want.out_bytes || out_data.byte_count !== want.byte_count ||
            out_data.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t mismatch (exp/got): bytes %h/%h count %0d/%0d last %0b/%0b",
                     $realtime, want.out_bytes, out_data.out_bytes, want.byte_count,
                     out_data.byte_count, want.last_of_run, out_data.last_of_run);
        end
      end
    end
  end

  // ends the run when no beat moves for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results still due", QUIET_LIMIT,
               pending_frames.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls in stretches, one long hold-off to back the block up
  initial begin : result_sink
    int  g;
    int  stretch;
    bit  calm;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      stretch = $urandom_range(10, 60);
      calm    = ($urandom_range(0, 3) == 0);
      repeat (stretch) begin
        if (!hold_done && frames_seen >= HOLD_AFTER) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_done = 1'b1;
        end else begin
          g = calm ? 0 : idle_len();
          if (g > 0) begin
            out_stall <= 1'b1;
            repeat (g) @(posedge clk);
          end
        end
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // offer one beat and wait for it to be taken; valid stays up between beats unless a random idle gap comes first
  task automatic send_beat(input in_t b, input check_tag_t t);
    int g;
    if (sender_left == 0) begin
      sender_left = $urandom_range(5, 40);
      sender_calm = ($urandom_range(0, 3) == 0);
    end
    sender_left--;
    g = sender_calm ? 0 : idle_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    beat_tag <= t;
    do @(posedge clk); while (in_stall);
  endtask

  // mostly runs of consecutive addresses, plus ends, transfers (when with_xfer is set) and stray beats
  task automatic random_phase(input int target, input bit with_xfer);
    int          n;
    int          k;
    int          len;
    logic [15:0] a;
    in_t         b;
    n = 0;
    while (n < target) begin
      k = $urandom_range(0, 99);
      b.address = 16'($urandom);
      b.value   = 8'($urandom);
      if (k < 70) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0:       a = run_next;
          1:       a = 16'(16'hFFFF - $urandom_range(0, 3));
          default: a = 16'($urandom);
        endcase
        repeat (len) begin
          b.action  = ACT_DATA;
          b.address = a;
          b.value   = 8'($urandom);
          send_beat(b, PREDICT);
          n++;
          // an occasional hole breaks the run
          a = ($urandom_range(0, 29) == 0) ? a + 16'd2 : a + 16'd1;
        end
        run_next = a;
      end else if (k < 80) begin
        b.action = ACT_END;
        send_beat(b, PREDICT);
        n++;
        run_next = 16'd1;
      end else if (k < 90 && with_xfer) begin
        if ($urandom_range(0, 4) == 0) b.address = 16'hFFFF;
        b.action = ACT_XFER;
        send_beat(b, PREDICT);
        n++;
        run_next = b.address + 16'd1;
      end else begin
        b.action = ($urandom_range(0, 1) == 0) ? ACT_UNUSED : ACT_DATA;
        send_beat(b, PREDICT);
        n++;
      end
    end
  endtask

  initial begin : stimulus
    int r;
    buf_fill     = 0;
    buf_base     = '0;
    last_addr    = '0;
    last_ok      = 1'b0;
    xfer_seen    = 1'b0;
    beats_in     = 0;
    frames_seen  = 0;
    load_records = 0;
    mismatches   = 0;
    hold_done    = 1'b0;
    sender_left  = 0;
    sender_calm  = 1'b0;
    run_next     = '0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    beat_tag <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // end records still work up to the first transfer, so transfers only come in the second half
    for (r = 0; r < XFER_ROW; r++) send_beat(dir_rows[r].beat, dir_rows[r].tag);
    random_phase(80, 1'b0);
    for (r = XFER_ROW; r < N_ROWS; r++) send_beat(dir_rows[r].beat, dir_rows[r].tag);
    random_phase(70, 1'b1);
    in_valid <= 1'b0;

    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input beats and %0d result beats, %0d load records,",
             beats_in, frames_seen, load_records);
    $display("a %0d-cycle receiver hold-off, breaks, transfers and ends; %0d mismatches",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
